// File: src/rcp_pkg.sv
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types and constants for the request command parser.
// ----------------------------------------------------------------------------
package rcp_pkg;

    // length lines wrap at this width (8 to 32)
    localparam int LEN_W   = 32;
    localparam int KEY_W   = 64;
    localparam int OUT_LEN_W = 32;
    localparam int SEQ_W   = 32;

    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;

    localparam logic [23:0] NAME_SET = "SET";
    localparam logic [23:0] NAME_GET = "GET";
    localparam logic [23:0] NAME_DEL = "DEL";

    // sequence numbers count modulo 2^32 - 1
    localparam logic [SEQ_W-1:0] SEQ_LAST = {SEQ_W{1'b1}} - SEQ_W'(1);

    typedef enum logic [3:0] {
        PH_CNT     = 4'd0,
        PH_CNT_LF  = 4'd1,
        PH_TLEN    = 4'd2,
        PH_TLEN_LF = 4'd3,
        PH_TDATA   = 4'd4,
        PH_TEND    = 4'd5,
        PH_KLEN    = 4'd6,
        PH_KLEN_LF = 4'd7,
        PH_KDATA   = 4'd8,
        PH_KEND    = 4'd9,
        PH_VLEN    = 4'd10,
        PH_VLEN_LF = 4'd11,
        PH_VDATA   = 4'd12,
        PH_VEND    = 4'd13
    } rcp_phase_t;

    typedef enum logic [1:0] {
        CMD_UNK = 2'd0,
        CMD_SET = 2'd1,
        CMD_GET = 2'd2,
        CMD_DEL = 2'd3
    } rcp_cmd_t;

    typedef enum logic {
        KIND_VALUE   = 1'b0,
        KIND_COMMAND = 1'b1
    } rcp_kind_t;

    typedef struct packed {
        rcp_kind_t            kind;
        logic [7:0]           value_byte;
        logic                 value_last;
        rcp_cmd_t             command;
        logic [KEY_W-1:0]     key_number;
        logic [OUT_LEN_W-1:0] value_length;
        logic [SEQ_W-1:0]     sequence_res;
    } rcp_res_t;

endpackage

// File: src/resp_command_parser.sv
// ----------------------------------------------------------------------------
// resp_command_parser
// Byte-serial parser for array-of-bulk-string requests (SET, GET, DEL).
// ----------------------------------------------------------------------------
//  channel | dir | tdata                        | tuser | tlast
//  s_      | in  | request byte                 | -     | -
//  m_      | out | value byte / command fields  | kind  | last value byte
//
//  One request byte per cycle sustained while m_tready is high; the byte
//  passes an input register and the parse logic, and its result is stored
//  in the output register. The parse step is a single pass per byte.
//  Reset is synchronous on aresetn and leaves the parser at the count line.
//  While m_tready is low the result holds and one more byte may be taken.
// ----------------------------------------------------------------------------
module resp_command_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // [7:0] value_byte, [9:8] command,
                                    // [73:10] key_number, [105:74] value_length,
                                    // [137:106] sequence_res, rest zero
    output logic         m_tuser,   // [0] kind
    output logic         m_tlast    // value_last
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    rcp_pkg::rcp_res_t out_reg;
    logic              out_free, step, res_valid;
    rcp_pkg::rcp_res_t res;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    rcp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .din       (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.value_last;
    assign m_tdata  = {6'd0, out_reg.sequence_res, out_reg.value_length,
                       out_reg.key_number, out_reg.command, out_reg.value_byte};

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_no_step_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> in_valid_reg && (!out_valid_reg || m_tready))
        else $error("parse step without a free result slot");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted request byte lost");

endmodule

// File: src/rcp_core.sv
// ----------------------------------------------------------------------------
// rcp_core
// Parse state and per-byte decode: one byte per step, at most one result.
// ----------------------------------------------------------------------------
module rcp_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       din,
    output logic             res_valid,
    output rcp_pkg::rcp_res_t res
);

    localparam int LW = rcp_pkg::LEN_W;
    localparam int KW = rcp_pkg::KEY_W;
    localparam int SW = rcp_pkg::SEQ_W;

    rcp_pkg::rcp_phase_t phase_reg, phase_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [7:0]          tb_reg [4];
    logic [7:0]          tb_next [4];
    logic [LW-1:0]       fr_reg, fr_next;
    logic [KW-1:0]       key_reg, key_next;
    rcp_pkg::rcp_cmd_t   cmd_reg, cmd_next;
    logic [LW-1:0]       vlen_reg, vlen_next;
    logic [SW-1:0]       seq_reg, seq_next;

    logic          is_lf, is_cr, is_digit;
    logic [3:0]    digit;
    logic [LW-1:0] len_acc, fr_dec, type_idx;
    logic [KW-1:0] key_acc;
    logic          fr_last, len_zero;
    rcp_pkg::rcp_cmd_t cmd_match;
    logic          in_len_line, len_lf_wait, short_cmd;

    assign is_lf    = (din == rcp_pkg::CH_LF);
    assign is_cr    = (din == rcp_pkg::CH_CR);
    assign is_digit = (din >= rcp_pkg::CH_0) && (din <= rcp_pkg::CH_9);
    assign digit    = din[3:0];
    assign len_acc  = (len_reg << 3) + (len_reg << 1) + LW'(digit);
    assign key_acc  = (key_reg << 3) + (key_reg << 1) + KW'(digit);
    assign fr_dec   = fr_reg - LW'(1);
    assign fr_last  = (fr_dec == '0);
    assign len_zero = (len_reg == '0);
    assign type_idx = len_reg - fr_reg;
    assign short_cmd = (phase_reg == rcp_pkg::PH_KEND) &&
                       ((cmd_reg == rcp_pkg::CMD_GET) || (cmd_reg == rcp_pkg::CMD_DEL));

    assign in_len_line = (phase_reg == rcp_pkg::PH_TLEN) || (phase_reg == rcp_pkg::PH_TLEN_LF) ||
                         (phase_reg == rcp_pkg::PH_KLEN) || (phase_reg == rcp_pkg::PH_KLEN_LF) ||
                         (phase_reg == rcp_pkg::PH_VLEN) || (phase_reg == rcp_pkg::PH_VLEN_LF);
    assign len_lf_wait = (phase_reg == rcp_pkg::PH_TLEN_LF) ||
                         (phase_reg == rcp_pkg::PH_KLEN_LF) ||
                         (phase_reg == rcp_pkg::PH_VLEN_LF);

    always_comb begin
        cmd_match = rcp_pkg::CMD_UNK;
        if (len_reg == LW'(3)) begin
            if ({tb_reg[0], tb_reg[1], tb_reg[2]} == rcp_pkg::NAME_SET) begin
                cmd_match = rcp_pkg::CMD_SET;
            end else if ({tb_reg[0], tb_reg[1], tb_reg[2]} == rcp_pkg::NAME_GET) begin
                cmd_match = rcp_pkg::CMD_GET;
            end else if ({tb_reg[0], tb_reg[1], tb_reg[2]} == rcp_pkg::NAME_DEL) begin
                cmd_match = rcp_pkg::CMD_DEL;
            end
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            rcp_pkg::PH_TLEN, rcp_pkg::PH_TLEN_LF: begin
                if (is_lf) begin
                    phase_next = len_zero ? rcp_pkg::PH_TEND : rcp_pkg::PH_TDATA;
                end else if (!len_lf_wait && is_cr) begin
                    phase_next = rcp_pkg::PH_TLEN_LF;
                end
            end
            rcp_pkg::PH_KLEN, rcp_pkg::PH_KLEN_LF: begin
                if (is_lf) begin
                    phase_next = len_zero ? rcp_pkg::PH_KEND : rcp_pkg::PH_KDATA;
                end else if (!len_lf_wait && is_cr) begin
                    phase_next = rcp_pkg::PH_KLEN_LF;
                end
            end
            rcp_pkg::PH_VLEN, rcp_pkg::PH_VLEN_LF: begin
                if (is_lf) begin
                    phase_next = len_zero ? rcp_pkg::PH_VEND : rcp_pkg::PH_VDATA;
                end else if (!len_lf_wait && is_cr) begin
                    phase_next = rcp_pkg::PH_VLEN_LF;
                end
            end
            rcp_pkg::PH_TDATA: if (fr_last) phase_next = rcp_pkg::PH_TEND;
            rcp_pkg::PH_KDATA: if (fr_last) phase_next = rcp_pkg::PH_KEND;
            rcp_pkg::PH_VDATA: if (fr_last) phase_next = rcp_pkg::PH_VEND;
            rcp_pkg::PH_TEND:  if (is_lf) phase_next = rcp_pkg::PH_KLEN;
            rcp_pkg::PH_KEND: begin
                if (is_lf) begin
                    phase_next = short_cmd ? rcp_pkg::PH_CNT : rcp_pkg::PH_VLEN;
                end
            end
            rcp_pkg::PH_VEND:  if (is_lf) phase_next = rcp_pkg::PH_CNT;
            default: begin
                // count line and its line feed wait; stray codes fold back here
                if (is_lf) begin
                    phase_next = rcp_pkg::PH_TLEN;
                end else if (is_cr) begin
                    phase_next = rcp_pkg::PH_CNT_LF;
                end else if (phase_reg != rcp_pkg::PH_CNT_LF) begin
                    phase_next = rcp_pkg::PH_CNT;
                end
            end
        endcase
    end

    // datapath next values
    always_comb begin
        logic clear_cmd;
        clear_cmd = 1'b0;
        len_next  = len_reg;
        tb_next   = tb_reg;
        fr_next   = fr_reg;
        key_next  = key_reg;
        cmd_next  = cmd_reg;
        vlen_next = vlen_reg;
        seq_next  = seq_reg;
        if (in_len_line) begin
            if (is_lf) begin
                fr_next = len_reg;
                if ((phase_reg == rcp_pkg::PH_VLEN) || (phase_reg == rcp_pkg::PH_VLEN_LF)) begin
                    vlen_next = len_reg;
                end
            end else if (!len_lf_wait && !is_cr && is_digit) begin
                len_next = len_acc;
            end
        end else begin
            case (phase_reg)
                rcp_pkg::PH_TDATA: begin
                    if (type_idx[LW-1:2] == '0) begin
                        tb_next[type_idx[1:0]] = din;
                    end
                    fr_next = fr_dec;
                end
                rcp_pkg::PH_KDATA: begin
                    if (is_digit) begin
                        key_next = key_acc;
                    end
                    fr_next = fr_dec;
                end
                rcp_pkg::PH_VDATA: fr_next = fr_dec;
                rcp_pkg::PH_TEND: begin
                    if (is_lf) begin
                        cmd_next = cmd_match;
                        len_next = '0;
                    end
                end
                rcp_pkg::PH_KEND: begin
                    if (is_lf) begin
                        if (short_cmd) begin
                            clear_cmd = 1'b1;
                            if (cmd_reg == rcp_pkg::CMD_GET) begin
                                seq_next = (seq_reg == rcp_pkg::SEQ_LAST) ? '0
                                                                          : seq_reg + SW'(1);
                            end
                        end else begin
                            len_next = '0;
                        end
                    end
                end
                rcp_pkg::PH_VEND: clear_cmd = is_lf;
                default: begin
                    if (is_lf) begin
                        len_next = '0;
                    end
                end
            endcase
        end
        if (clear_cmd) begin
            len_next  = '0;
            tb_next   = '{default: '0};
            fr_next   = '0;
            key_next  = '0;
            cmd_next  = rcp_pkg::CMD_UNK;
            vlen_next = '0;
        end
    end

    // results
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        unique case (phase_reg)
            rcp_pkg::PH_VDATA: begin
                res_valid      = 1'b1;
                res.kind       = rcp_pkg::KIND_VALUE;
                res.value_byte = din;
                res.value_last = fr_last;
            end
            rcp_pkg::PH_KEND: begin
                res_valid        = is_lf && short_cmd;
                res.kind         = rcp_pkg::KIND_COMMAND;
                res.command      = cmd_reg;
                res.key_number   = key_reg;
                res.sequence_res = (cmd_reg == rcp_pkg::CMD_GET) ? seq_reg : '0;
            end
            rcp_pkg::PH_VEND: begin
                res_valid        = is_lf;
                res.kind         = rcp_pkg::KIND_COMMAND;
                res.command      = cmd_reg;
                res.key_number   = key_reg;
                res.value_length = rcp_pkg::OUT_LEN_W'(vlen_reg);
            end
            default: res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rcp_pkg::PH_CNT;
            len_reg   <= '0;
            tb_reg    <= '{default: '0};
            fr_reg    <= '0;
            key_reg   <= '0;
            cmd_reg   <= rcp_pkg::CMD_UNK;
            vlen_reg  <= '0;
            seq_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            tb_reg    <= tb_next;
            fr_reg    <= fr_next;
            key_reg   <= key_next;
            cmd_reg   <= cmd_next;
            vlen_reg  <= vlen_next;
            seq_reg   <= seq_next;
        end
    end

    a_seq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg != '1)
        else $error("get sequence left its range");

    a_cmd_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res_valid && (res.kind == rcp_pkg::KIND_COMMAND)
        |=> (phase_reg == rcp_pkg::PH_CNT) && (key_reg == '0))
        else $error("command result did not restart the parser");

    a_value_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res_valid && (res.kind == rcp_pkg::KIND_VALUE) && res.value_last
        |=> (phase_reg == rcp_pkg::PH_VEND))
        else $error("last value byte did not end the payload");

    a_empty_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == rcp_pkg::PH_TDATA || phase_reg == rcp_pkg::PH_KDATA ||
         phase_reg == rcp_pkg::PH_VDATA) |-> (fr_reg != '0))
        else $error("payload phase with no bytes left");

endmodule
